[src/aprep_pkg.sv]
`timescale 1ns / 1ps

package aprep_pkg;

   localparam int NUM_PROCS      = 16;
   localparam int PAGES_PER_PROC = 256;
   localparam int NUM_FRAMES     = 1024;
   localparam int ESSENTIAL      = 10;
   localparam int MIN_FREE_RESET = 64;

   localparam int PID_W  = $clog2(NUM_PROCS);
   localparam int PG_W   = $clog2(PAGES_PER_PROC);
   localparam int IDX_W  = PID_W + PG_W;
   localparam int FR_W   = $clog2(NUM_FRAMES);
   localparam int FC_W   = FR_W + 1;
   localparam int HIST_W = 16;
   localparam int RND_W  = 16;

   localparam logic [HIST_W-1:0] HIST_FULL = 16'hFFFF;

   localparam logic [1:0] CMD_ACCESS  = 2'd0;
   localparam logic [1:0] CMD_AGE     = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_SETUP   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_NO_VICTIM = 2'd2;

   localparam logic [2:0] KIND_OWNER_PAGE = 3'd0;
   localparam logic [2:0] KIND_UNOWNED    = 3'd1;
   localparam logic [2:0] KIND_OWNER      = 3'd2;
   localparam logic [2:0] KIND_RANDOM     = 3'd3;
   localparam logic [2:0] KIND_NONE       = 3'd4;

   typedef struct packed {
      logic              valid;
      logic              refd;
      logic [FR_W-1:0]   frame;
      logic [HIST_W-1:0] hist;
   } pte_type;

   typedef struct packed {
      logic             owned;
      logic [PID_W-1:0] owner;
      logic [PG_W-1:0]  page;
      logic [FR_W-1:0]  frame;
   } slot_type;

endpackage

[src/aging_page_replacement_engine_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tuser: cmd; tdata: process_id, page, rand_value
// rsp      out        rsp_tvalid/tready     tdata: status .. free_count_out
// csr      in         csr_wr_en             csr_wr_data: min_free_frames
//
// One command is handled at a time; the page-table memory and the frame pool memory each
// give one read and take one write per cycle. An access reads its entry in S_ACC_RD and
// checks it in S_ACC_CHK (a plain load adds S_ACC_LOAD); S_DONE loads the result, which
// waits in the output register, once that register is free. The next request is taken in
// S_IDLE. Age, release and a replacement scan the process's pages at one entry a cycle; a
// replacement then scans the pool slots below the free count at one slot a cycle and may
// run the remainder unit. After reset a clearing pass runs before any request is taken.

module aging_page_replacement_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [31:0] req_tdata,   // process_id, page, rand_value, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, hit, fault, replaced, frame_out, victim_page,
                                    // attempt_kind, free_count_out, zero fill
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data  // min_free_frames
);

   localparam int PID_W  = aprep_pkg::PID_W;
   localparam int PG_W   = aprep_pkg::PG_W;
   localparam int IDX_W  = aprep_pkg::IDX_W;
   localparam int FR_W   = aprep_pkg::FR_W;
   localparam int FC_W   = aprep_pkg::FC_W;
   localparam int RND_W  = aprep_pkg::RND_W;
   localparam int NPAGE  = 1 << IDX_W;

   localparam logic [4:0] S_CLR      = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ACC_RD   = 5'd2;
   localparam logic [4:0] S_ACC_CHK  = 5'd3;
   localparam logic [4:0] S_ACC_LOAD = 5'd4;
   localparam logic [4:0] S_VSCAN    = 5'd5;
   localparam logic [4:0] S_PSCAN    = 5'd6;
   localparam logic [4:0] S_DIV      = 5'd7;
   localparam logic [4:0] S_PRD      = 5'd8;
   localparam logic [4:0] S_PWR      = 5'd9;
   localparam logic [4:0] S_NEWPG    = 5'd10;
   localparam logic [4:0] S_AGE      = 5'd11;
   localparam logic [4:0] S_REL      = 5'd12;
   localparam logic [4:0] S_SET_RD   = 5'd13;
   localparam logic [4:0] S_SET_CHK  = 5'd14;
   localparam logic [4:0] S_SET_LOAD = 5'd15;
   localparam logic [4:0] S_DONE     = 5'd16;

   localparam logic [PG_W-1:0] PG_LAST  = PG_W'(aprep_pkg::PAGES_PER_PROC - 1);
   localparam logic [PG_W-1:0] PG_ESS   = PG_W'(aprep_pkg::ESSENTIAL);
   localparam logic [PG_W-1:0] ESS_LAST = PG_W'(aprep_pkg::ESSENTIAL - 1);
   localparam logic [FC_W-1:0] FC_FULL  = FC_W'(aprep_pkg::NUM_FRAMES);

   aprep_pkg::pte_type  page_mem [NPAGE];
   aprep_pkg::slot_type pool_mem [aprep_pkg::NUM_FRAMES];

   aprep_pkg::pte_type  pm_rd_ff, pm_wdata;
   aprep_pkg::slot_type pl_rd_ff, pl_wdata;
   logic [IDX_W-1:0]    pm_raddr, pm_waddr;
   logic [FR_W-1:0]     pl_raddr, pl_waddr;
   logic                pm_we, pl_we;

   logic [4:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [FC_W-1:0]  fc_ff, fc_in, min_ff, min_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in, rd_vld_ff, rd_vld_in;
   logic [39:0]      rsp_tdata_ff, rsp_tdata_in;

   logic [PID_W-1:0] pid_ff, pid_in;
   logic [PG_W-1:0]  pg_ff, pg_in, scan_ff, scan_in, rd_pg_ff, rd_pg_in, vic_ff, vic_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic             scan_end_ff, scan_end_in, ps_end_ff, ps_end_in;
   logic [FR_W-1:0]  ps_ff, ps_in, rd_ps_ff, rd_ps_in, vfr_ff, vfr_in, sel_ff, sel_in;
   logic [FR_W-1:0]  s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in, chosen_ff, chosen_in;
   logic             m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic [16:0]      best_ff, best_in;
   logic             found_ff, found_in, pool_use_ff, pool_use_in;
   logic [FC_W-1:0]  rem_ff, rem_in;
   logic [3:0]       bit_ff, bit_in;

   logic [1:0]       status_ff, status_in;
   logic             hit_ff, hit_in, fault_ff, fault_in, repl_ff, repl_in;
   logic [FR_W-1:0]  frame_ff, frame_in;
   logic [PG_W-1:0]  victim_ff, victim_in;
   logic [2:0]       kind_ff, kind_in;

   logic             can_take, load_rsp;
   logic [FC_W-1:0]  fc_dec;
   logic [FC_W:0]    trial;

   assign can_take   = (fc_ff > min_ff) && (fc_ff != '0);
   assign fc_dec     = fc_ff - FC_W'(1);
   assign trial      = {rem_ff, rnd_ff[bit_ff]};
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (pm_we) begin
         page_mem[pm_waddr] <= pm_wdata;
      end
      pm_rd_ff <= page_mem[pm_raddr];
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         pool_mem[pl_waddr] <= pl_wdata;
      end
      pl_rd_ff <= pool_mem[pl_raddr];
   end

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;  fc_in = fc_ff;
      min_in = csr_wr_en ? csr_wr_data : min_ff;
      rsp_tdata_in = rsp_tdata_ff;  rd_vld_in = 1'b0;
      pid_in = pid_ff;  pg_in = pg_ff;  rnd_in = rnd_ff;
      scan_in = scan_ff;  scan_end_in = scan_end_ff;  rd_pg_in = scan_ff;
      ps_in = ps_ff;  ps_end_in = ps_end_ff;  rd_ps_in = ps_ff;
      vic_in = vic_ff;  vfr_in = vfr_ff;  sel_in = sel_ff;  chosen_in = chosen_ff;
      s0_in = s0_ff;  s1_in = s1_ff;  s2_in = s2_ff;
      m0_in = m0_ff;  m1_in = m1_ff;  m2_in = m2_ff;
      best_in = best_ff;  found_in = found_ff;  pool_use_in = pool_use_ff;
      rem_in = rem_ff;  bit_in = bit_ff;
      status_in = status_ff;  hit_in = hit_ff;  fault_in = fault_ff;  repl_in = repl_ff;
      frame_in = frame_ff;  victim_in = victim_ff;  kind_in = kind_ff;
      pm_raddr = {pid_ff, scan_ff};
      pl_raddr = ps_ff;
      pm_we = 1'b0;  pm_waddr = {pid_ff, rd_pg_ff};  pm_wdata = pm_rd_ff;
      pl_we = 1'b0;  pl_waddr = fc_ff[FR_W-1:0];   pl_wdata = pl_rd_ff;
      load_rsp = 1'b0;

      if ((state_ff == S_VSCAN || state_ff == S_AGE || state_ff == S_REL) && !scan_end_ff) begin
         rd_vld_in = 1'b1;
         if (scan_ff == PG_LAST) begin
            scan_end_in = 1'b1;
         end else begin
            scan_in = scan_ff + PG_W'(1);
         end
      end

      case (state_ff)
         S_CLR: begin
            pm_we = 1'b1;  pm_waddr = clr_ff;  pm_wdata = '0;
            if (clr_ff < IDX_W'(aprep_pkg::NUM_FRAMES)) begin
               pl_we = 1'b1;  pl_waddr = clr_ff[FR_W-1:0];
               pl_wdata = '{owned: 1'b0, owner: '0, page: '0, frame: clr_ff[FR_W-1:0]};
            end
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(NPAGE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               pid_in = req_tdata[3:0];  pg_in = req_tdata[11:4];  rnd_in = req_tdata[27:12];
               status_in = aprep_pkg::ST_OK;  hit_in = 1'b0;  fault_in = 1'b0;
               repl_in = 1'b0;  frame_in = '0;  victim_in = '0;
               kind_in = aprep_pkg::KIND_NONE;  scan_end_in = 1'b0;  scan_in = '0;
               case (req_tuser)
                  aprep_pkg::CMD_ACCESS:  state_in = S_ACC_RD;
                  aprep_pkg::CMD_AGE: begin
                     state_in = S_AGE;  scan_in = PG_ESS;
                  end
                  aprep_pkg::CMD_RELEASE: state_in = S_REL;
                  default:                state_in = S_SET_RD;
               endcase
            end
         end
         S_ACC_RD: begin
            pm_raddr = {pid_ff, pg_ff};
            state_in = S_ACC_CHK;
         end
         S_ACC_CHK: begin
            pm_waddr = {pid_ff, pg_ff};
            if (pm_rd_ff.valid) begin
               pm_we = 1'b1;  pm_wdata.refd = 1'b1;
               hit_in = 1'b1;  frame_in = pm_rd_ff.frame;  state_in = S_DONE;
            end else if (can_take) begin
               pl_raddr = fc_dec[FR_W-1:0];  state_in = S_ACC_LOAD;
            end else begin
               scan_in = PG_ESS;  scan_end_in = 1'b0;  best_in = 17'h10000;
               found_in = 1'b0;  state_in = S_VSCAN;
            end
         end
         S_ACC_LOAD: begin
            pm_we = 1'b1;  pm_waddr = {pid_ff, pg_ff};
            pm_wdata = '{valid: 1'b1, refd: 1'b1, frame: pl_rd_ff.frame,
                         hist: aprep_pkg::HIST_FULL};
            fc_in = fc_dec;  fault_in = 1'b1;  frame_in = pl_rd_ff.frame;
            kind_in = aprep_pkg::KIND_NONE;  state_in = S_DONE;
         end
         S_VSCAN: begin
            if (rd_vld_ff && pm_rd_ff.valid && {1'b0, pm_rd_ff.hist} < best_ff) begin
               best_in = {1'b0, pm_rd_ff.hist};  vic_in = rd_pg_ff;
               vfr_in = pm_rd_ff.frame;  found_in = 1'b1;
            end
            if (scan_end_ff && !rd_vld_ff) begin
               if (!found_ff) begin
                  status_in = aprep_pkg::ST_NO_VICTIM;  state_in = S_DONE;
               end else if (fc_ff == '0) begin
                  pool_use_in = 1'b0;  kind_in = aprep_pkg::KIND_NONE;  state_in = S_PWR;
               end else begin
                  ps_in = '0;  ps_end_in = 1'b0;  m0_in = 1'b0;  m1_in = 1'b0;
                  m2_in = 1'b0;  state_in = S_PSCAN;
               end
            end
         end
         S_PSCAN: begin
            if (!ps_end_ff) begin
               rd_vld_in = 1'b1;
               if ({1'b0, ps_ff} == fc_dec) begin
                  ps_end_in = 1'b1;
               end else begin
                  ps_in = ps_ff + FR_W'(1);
               end
            end
            if (rd_vld_ff) begin
               if (!m0_ff && pl_rd_ff.owned && pl_rd_ff.owner == pid_ff &&
                   pl_rd_ff.page == pg_ff) begin
                  m0_in = 1'b1;  s0_in = rd_ps_ff;
               end
               if (!m1_ff && !pl_rd_ff.owned) begin
                  m1_in = 1'b1;  s1_in = rd_ps_ff;
               end
               if (!m2_ff && pl_rd_ff.owned && pl_rd_ff.owner == pid_ff) begin
                  m2_in = 1'b1;  s2_in = rd_ps_ff;
               end
            end
            if (ps_end_ff && !rd_vld_ff) begin
               pool_use_in = 1'b1;  state_in = S_PRD;
               if (m0_ff) begin
                  sel_in = s0_ff;  kind_in = aprep_pkg::KIND_OWNER_PAGE;
               end else if (m1_ff) begin
                  sel_in = s1_ff;  kind_in = aprep_pkg::KIND_UNOWNED;
               end else if (m2_ff) begin
                  sel_in = s2_ff;  kind_in = aprep_pkg::KIND_OWNER;
               end else begin
                  kind_in = aprep_pkg::KIND_RANDOM;  rem_in = '0;
                  bit_in = 4'(RND_W - 1);  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (trial >= {1'b0, fc_ff}) begin
               rem_in = FC_W'(trial - {1'b0, fc_ff});
            end else begin
               rem_in = trial[FC_W-1:0];
            end
            bit_in = bit_ff - 4'd1;
            if (bit_ff == '0) begin
               sel_in = rem_in[FR_W-1:0];  state_in = S_PRD;
            end
         end
         S_PRD: begin
            pl_raddr = sel_ff;  state_in = S_PWR;
         end
         S_PWR: begin
            chosen_in = pool_use_ff ? pl_rd_ff.frame : vfr_ff;
            pl_we = pool_use_ff;  pl_waddr = sel_ff;
            pl_wdata = '{owned: 1'b1, owner: pid_ff, page: vic_ff, frame: vfr_ff};
            pm_we = 1'b1;  pm_waddr = {pid_ff, vic_ff};  pm_wdata = '0;
            state_in = S_NEWPG;
         end
         S_NEWPG: begin
            pm_we = 1'b1;  pm_waddr = {pid_ff, pg_ff};
            pm_wdata = '{valid: 1'b1, refd: 1'b1, frame: chosen_ff,
                         hist: aprep_pkg::HIST_FULL};
            fault_in = 1'b1;  repl_in = 1'b1;  frame_in = chosen_ff;
            victim_in = vic_ff;  state_in = S_DONE;
         end
         S_AGE: begin
            if (rd_vld_ff && pm_rd_ff.valid) begin
               pm_we = 1'b1;
               pm_wdata.refd = 1'b0;
               pm_wdata.hist = {pm_rd_ff.refd, pm_rd_ff.hist[15:1]};
            end
            if (scan_end_ff && !rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_REL: begin
            if (rd_vld_ff && pm_rd_ff.valid) begin
               pm_we = 1'b1;  pm_wdata.valid = 1'b0;
               if (fc_ff < FC_FULL) begin
                  pl_we = 1'b1;
                  pl_wdata = '{owned: 1'b0, owner: '0, page: '0, frame: pm_rd_ff.frame};
                  fc_in = fc_ff + FC_W'(1);
               end
            end
            if (scan_end_ff && !rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_SET_RD: begin
            state_in = S_SET_CHK;
         end
         S_SET_CHK: begin
            if (pm_rd_ff.valid) begin
               scan_in = scan_ff + PG_W'(1);
               state_in = (scan_ff == ESS_LAST) ? S_DONE : S_SET_RD;
            end else if (can_take) begin
               pl_raddr = fc_dec[FR_W-1:0];  state_in = S_SET_LOAD;
            end else begin
               status_in = aprep_pkg::ST_NO_FREE;  state_in = S_DONE;
            end
         end
         S_SET_LOAD: begin
            pm_we = 1'b1;  pm_waddr = {pid_ff, scan_ff};
            pm_wdata = '{valid: 1'b1, refd: 1'b0, frame: pl_rd_ff.frame,
                         hist: aprep_pkg::HIST_FULL};
            fc_in = fc_dec;  scan_in = scan_ff + PG_W'(1);
            state_in = (scan_ff == ESS_LAST) ? S_DONE : S_SET_RD;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               rsp_tdata_in = {3'b000, fc_ff, kind_in, victim_ff, frame_ff, repl_ff,
                               fault_ff, hit_ff, status_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         fc_ff         <= FC_FULL;
         min_ff        <= FC_W'(aprep_pkg::MIN_FREE_RESET);
         rsp_tvalid_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         fc_ff         <= fc_in;
         min_ff        <= min_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      pid_ff <= pid_in;  pg_ff <= pg_in;  rnd_ff <= rnd_in;
      scan_ff <= scan_in;  scan_end_ff <= scan_end_in;  rd_pg_ff <= rd_pg_in;
      ps_ff <= ps_in;  ps_end_ff <= ps_end_in;  rd_ps_ff <= rd_ps_in;
      vic_ff <= vic_in;  vfr_ff <= vfr_in;  sel_ff <= sel_in;  chosen_ff <= chosen_in;
      s0_ff <= s0_in;  s1_ff <= s1_in;  s2_ff <= s2_in;
      m0_ff <= m0_in;  m1_ff <= m1_in;  m2_ff <= m2_in;
      best_ff <= best_in;  found_ff <= found_in;  pool_use_ff <= pool_use_in;
      rem_ff <= rem_in;  bit_ff <= bit_in;
      status_ff <= status_in;  hit_ff <= hit_in;  fault_ff <= fault_in;
      repl_ff <= repl_in;  frame_ff <= frame_in;  victim_ff <= victim_in;
      kind_ff <= kind_in;
   end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 8000000;
   localparam int NPTE = aprep_pkg::NUM_PROCS * aprep_pkg::PAGES_PER_PROC;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  pid;
      logic [7:0]  page;
      logic [15:0] rnd;
   } page_cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic        fault;
      logic        replaced;
      logic [9:0]  frame;
      logic [7:0]  victim;
      logic [2:0]  kind;
      logic [10:0] fcount;
   } page_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;

   aging_page_replacement_engine_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the page tables, histories and frame pool.
   logic        pte_valid [NPTE];
   logic        pte_ref   [NPTE];
   logic [9:0]  pte_frame [NPTE];
   logic [15:0] pte_hist  [NPTE];
   logic        slot_owned [aprep_pkg::NUM_FRAMES];
   logic [3:0]  slot_owner [aprep_pkg::NUM_FRAMES];
   logic [7:0]  slot_page  [aprep_pkg::NUM_FRAMES];
   logic [9:0]  slot_frame [aprep_pkg::NUM_FRAMES];
   int unsigned free_frames;
   int unsigned min_free;

   page_cmd_type pending_cmds[$];
   page_rsp_type expected_rsps[$];
   int          errors = 0;
   int          cycles = 0;
   bit          calm = 1'b0;
   bit          req_acc = 1'b0;
   bit          rsp_acc = 1'b0;
   int          req_gap = 0;
   int          rsp_stall = 0;

   function automatic bit grab_frame(output logic [9:0] fr);
      if (free_frames > min_free && free_frames > 0) begin
         free_frames--;
         fr = slot_frame[free_frames];
         return 1'b1;
      end
      fr = '0;
      return 1'b0;
   endfunction

   function automatic void install_page(int idx, logic [9:0] fr);
      pte_valid[idx] = 1'b1;
      pte_ref[idx]   = 1'b0;
      pte_frame[idx] = fr;
      pte_hist[idx]  = aprep_pkg::HIST_FULL;
   endfunction

   function automatic page_rsp_type run_command(page_cmd_type c);
      page_rsp_type r;
      int          base;
      int          idx;
      int          vic;
      int          sel;
      int unsigned best;
      bit          found;
      bit          got;
      logic [9:0]  fr;
      logic [9:0]  vfr;
      logic [9:0]  chosen;
      r = '0;
      r.kind = aprep_pkg::KIND_NONE;
      base = int'(c.pid) * aprep_pkg::PAGES_PER_PROC;
      idx = base + int'(c.page);
      case (c.cmd)
         aprep_pkg::CMD_ACCESS: begin
            if (pte_valid[idx]) begin
               r.hit = 1'b1;
               pte_ref[idx] = 1'b1;
               r.frame = pte_frame[idx];
            end else if (grab_frame(fr)) begin
               install_page(idx, fr);
               pte_ref[idx] = 1'b1;
               r.fault = 1'b1;
               r.frame = fr;
            end else begin
               best = 32'h10000;
               found = 1'b0;
               vic = 0;
               for (int i = aprep_pkg::ESSENTIAL; i < aprep_pkg::PAGES_PER_PROC; i++) begin
                  if (pte_valid[base+i] && pte_hist[base+i] < best) begin
                     best = pte_hist[base+i];
                     vic = i;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  r.status = aprep_pkg::ST_NO_VICTIM;
               end else begin
                  vfr = pte_frame[base+vic];
                  chosen = vfr;
                  if (free_frames > 0) begin
                     got = 1'b0;
                     sel = 0;
                     for (int i = 0; i < free_frames && !got; i++) begin
                        if (slot_owned[i] && slot_owner[i] == c.pid &&
                            slot_page[i] == c.page) begin
                           sel = i; r.kind = aprep_pkg::KIND_OWNER_PAGE; got = 1'b1;
                        end
                     end
                     for (int i = 0; i < free_frames && !got; i++) begin
                        if (!slot_owned[i]) begin
                           sel = i; r.kind = aprep_pkg::KIND_UNOWNED; got = 1'b1;
                        end
                     end
                     for (int i = 0; i < free_frames && !got; i++) begin
                        if (slot_owned[i] && slot_owner[i] == c.pid) begin
                           sel = i; r.kind = aprep_pkg::KIND_OWNER; got = 1'b1;
                        end
                     end
                     if (!got) begin
                        sel = int'(c.rnd) % free_frames;
                        r.kind = aprep_pkg::KIND_RANDOM;
                     end
                     chosen = slot_frame[sel];
                     slot_frame[sel] = vfr;
                     slot_owned[sel] = 1'b1;
                     slot_owner[sel] = c.pid;
                     slot_page[sel]  = vic[7:0];
                  end
                  pte_valid[base+vic] = 1'b0;
                  pte_ref[base+vic]   = 1'b0;
                  pte_hist[base+vic]  = '0;
                  install_page(idx, chosen);
                  pte_ref[idx] = 1'b1;
                  r.fault = 1'b1;
                  r.replaced = 1'b1;
                  r.frame = chosen;
                  r.victim = vic[7:0];
               end
            end
         end
         aprep_pkg::CMD_AGE: begin
            for (int i = aprep_pkg::ESSENTIAL; i < aprep_pkg::PAGES_PER_PROC; i++) begin
               if (pte_valid[base+i]) begin
                  pte_hist[base+i] = {pte_ref[base+i], pte_hist[base+i][15:1]};
                  pte_ref[base+i] = 1'b0;
               end
            end
         end
         aprep_pkg::CMD_RELEASE: begin
            for (int i = 0; i < aprep_pkg::PAGES_PER_PROC; i++) begin
               if (pte_valid[base+i]) begin
                  pte_valid[base+i] = 1'b0;
                  if (free_frames < aprep_pkg::NUM_FRAMES) begin
                     slot_frame[free_frames] = pte_frame[base+i];
                     slot_owned[free_frames] = 1'b0;
                     slot_owner[free_frames] = '0;
                     slot_page[free_frames]  = '0;
                     free_frames++;
                  end
               end
            end
         end
         default: begin
            for (int i = 0; i < aprep_pkg::ESSENTIAL && i < aprep_pkg::PAGES_PER_PROC;
                 i++) begin
               if (!pte_valid[base+i]) begin
                  if (!grab_frame(fr)) begin
                     r.status = aprep_pkg::ST_NO_FREE;
                     break;
                  end
                  install_page(base + i, fr);
               end
            end
         end
      endcase
      if (r.kind == aprep_pkg::KIND_NONE) begin
         r.frame = r.replaced || r.hit || r.fault ? r.frame : '0;
      end
      r.fcount = free_frames[10:0];
      return r;
   endfunction

   task automatic report(string field, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", field, got, want, cycles);
      errors++;
   endtask

   // Driver: new inputs at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_acc) begin
         end else if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_cmds.size() != 0) begin
            page_cmd_type c;
            c = pending_cmds.pop_front();
            req_tuser  <= c.cmd;
            req_tdata  <= {4'd0, c.rnd, c.page, c.pid};
            req_tvalid <= 1'b1;
            req_gap    <= calm ? 0 : $urandom_range(0, 10);
         end else begin
            req_tvalid <= 1'b0;
         end
         if (rsp_acc) begin
            rsp_tready <= calm;
            rsp_stall  <= calm ? 0 : $urandom_range(0, 10);
         end else if (rsp_stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: handshakes are sampled at the rising edge.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_acc <= !reset && req_tvalid && req_tready;
      rsp_acc <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) begin
         page_cmd_type c;
         c.cmd  = req_tuser;
         c.pid  = req_tdata[3:0];
         c.page = req_tdata[11:4];
         c.rnd  = req_tdata[27:12];
         expected_rsps.push_back(run_command(c));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         page_rsp_type want;
         if (expected_rsps.size() == 0) begin
            $display("unexpected response transaction (cycle %0d)", cycles);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tdata[1:0] !== want.status) report("status", rsp_tdata[1:0], want.status);
            if (rsp_tdata[2] !== want.hit) report("hit", rsp_tdata[2], want.hit);
            if (rsp_tdata[3] !== want.fault) report("fault", rsp_tdata[3], want.fault);
            if (rsp_tdata[4] !== want.replaced)
               report("replaced", rsp_tdata[4], want.replaced);
            if (rsp_tdata[14:5] !== want.frame) report("frame_out", rsp_tdata[14:5], want.frame);
            if (rsp_tdata[22:15] !== want.victim)
               report("victim_page", rsp_tdata[22:15], want.victim);
            if (rsp_tdata[25:23] !== want.kind)
               report("attempt_kind", rsp_tdata[25:23], want.kind);
            if (rsp_tdata[36:26] !== want.fcount)
               report("free_count_out", rsp_tdata[36:26], want.fcount);
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[aging_page_replacement_engine_core] ERROR");
         $finish;
      end
   end

   task automatic push_cmd(logic [1:0] cmd, int pid, int page, int rnd);
      page_cmd_type c;
      c.cmd  = cmd;
      c.pid  = pid[3:0];
      c.page = page[7:0];
      c.rnd  = rnd[15:0];
      pending_cmds.push_back(c);
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_min_free(int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[10:0];
      min_free = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_random(int count);
      int r;
      int pid;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         pid = ($urandom_range(0, 3) != 0) ? $urandom_range(4, 7) : $urandom_range(0, 15);
         push_cmd(r < 70 ? aprep_pkg::CMD_ACCESS : r < 85 ? aprep_pkg::CMD_AGE :
                  r < 93 ? aprep_pkg::CMD_SETUP : aprep_pkg::CMD_RELEASE,
                  pid,
                  ($urandom_range(0, 4) < 3) ? $urandom_range(0, 31) : $urandom_range(0, 255),
                  $urandom_range(0, 65535));
      end
   endtask

   initial begin
      int cfg_values[5];
      for (int i = 0; i < NPTE; i++) begin
         pte_valid[i] = 1'b0;
         pte_ref[i]   = 1'b0;
         pte_frame[i] = '0;
         pte_hist[i]  = '0;
      end
      for (int i = 0; i < aprep_pkg::NUM_FRAMES; i++) begin
         slot_owned[i] = 1'b0;
         slot_owner[i] = '0;
         slot_page[i]  = '0;
         slot_frame[i] = i[9:0];
      end
      free_frames = aprep_pkg::NUM_FRAMES;
      min_free = aprep_pkg::MIN_FREE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Basic operations at the reset threshold, with field extremes.
      push_cmd(aprep_pkg::CMD_SETUP, 0, 0, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 0, 0, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 0, 255, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 15, 128, 65535);
      push_cmd(aprep_pkg::CMD_ACCESS, 0, 255, 65535);
      push_cmd(aprep_pkg::CMD_AGE, 0, 255, 0);
      push_cmd(aprep_pkg::CMD_AGE, 0, 0, 0);
      push_cmd(aprep_pkg::CMD_RELEASE, 0, 0, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 0, 255, 12345);
      push_cmd(aprep_pkg::CMD_SETUP, 15, 0, 0);
      push_cmd(aprep_pkg::CMD_RELEASE, 15, 255, 65535);
      wait_idle();

      // Tight pool: setup failure and no victim.
      write_min_free(1020);
      push_cmd(aprep_pkg::CMD_SETUP, 1, 0, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 2, 40, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 1, 20, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 0, 100, 0);
      push_cmd(aprep_pkg::CMD_ACCESS, 0, 255, 0);
      push_cmd(aprep_pkg::CMD_SETUP, 1, 0, 0);
      wait_idle();

      // Fill part of the pool with back-to-back accesses from one process.
      write_min_free(0);
      calm = 1'b1;
      push_cmd(aprep_pkg::CMD_RELEASE, 1, 0, 0);
      for (int g = 0; g < 128; g++)
         push_cmd(aprep_pkg::CMD_ACCESS, 4, g, $urandom_range(0, 65535));
      push_cmd(aprep_pkg::CMD_ACCESS, 8, 50, 0);
      push_cmd(aprep_pkg::CMD_SETUP, 9, 0, 0);
      wait_idle();

      cfg_values = '{2047, 1024, $urandom_range(0, 1023), 0, 1000};
      for (int ph = 0; ph < 5; ph++) begin
         write_min_free(cfg_values[ph]);
         calm = (ph == 2);
         push_random(60);
         wait_idle();
      end
      write_min_free(aprep_pkg::MIN_FREE_RESET);
      push_random(20);
      wait_idle();

      if (errors == 0) begin
         $display("[aging_page_replacement_engine_core] OK");
      end else begin
         $display("[aging_page_replacement_engine_core] ERROR");
      end
      $finish;
   end

endmodule
